>>> hdl/lsplit_pkg.sv
// shared types and constants for the line splitter with output budget
// depends on nothing; used by the interfaces, the top level and the checker
package lsplit_pkg;

  localparam int MAX_LINE_W = 7;
  localparam int BUDGET_W   = 32;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [BYTE_W-1:0] CHAR_NL = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

  localparam logic [MAX_LINE_W-1:0] MAX_LINE_RESET = 7'd64;
  localparam logic [BUDGET_W-1:0]   BUDGET_RESET   = 32'hFFFF_FFFF;

  typedef enum logic {
    CMD_DATA   = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_LINE   = 2'd0,
    REG_BUDGET     = 2'd1,
    REG_STREAM_TAG = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND,
    ST_EMPTY
  } state_t;

endpackage

>>> hdl/lsplit_if.sv
// valid/ready channel interfaces for input items, result items and configuration
// depends on lsplit_pkg for field widths
interface lsplit_in_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic [lsplit_pkg::BYTE_W-1:0]   data_byte;
  modport source (output valid, cmd, data_byte, input ready);
  modport sink   (input valid, cmd, data_byte, output ready);
endinterface

interface lsplit_out_if;
  logic                            valid;
  logic                            ready;
  logic [lsplit_pkg::BYTE_W-1:0]   line_byte;
  logic                            byte_valid;
  logic                            last;
  logic                            truncated;
  logic                            stream;
  modport source (output valid, line_byte, byte_valid, last, truncated, stream, input ready);
  modport sink   (input valid, line_byte, byte_valid, last, truncated, stream, output ready);
endinterface

interface lsplit_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lsplit_pkg::CFG_IDX_W-1:0]    index;
  logic [lsplit_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/lsplit_ram.sv
// generic single-write, single-read ram with registered read data
// depends on nothing
module lsplit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/line_splitter_with_budget.sv
// line splitter: data bytes in, framed lines out, with line limit and byte budget
// a data byte is taken while idle; each byte of a line drains as a ram read (ST_READ)
// then an output register load (ST_SEND), an empty line as one load (ST_EMPTY); stalls hold the drain
// throughput: one input item per cycle between lines; no input is taken while draining
// reset: rst is synchronous active high; clears counters, marks and output valid, loads config defaults
// depends on lsplit_pkg, the lsplit interfaces and lsplit_ram
module line_splitter_with_budget #(
  parameter int MAX_LINE_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst,
  lsplit_in_if.sink           bytes,
  lsplit_out_if.source        lines,
  lsplit_cfg_if.sink          cfg
);

  // address bits for the line store, length bits hold 0..MAX_LINE_BYTES
  localparam int AW = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
  localparam int LW = $clog2(MAX_LINE_BYTES + 1);
  localparam logic [lsplit_pkg::MAX_LINE_W-1:0] MAX_LIMIT =
    lsplit_pkg::MAX_LINE_W'(MAX_LINE_BYTES);

  // configuration registers
  logic [lsplit_pkg::MAX_LINE_W-1:0] max_line;
  logic [lsplit_pkg::BUDGET_W-1:0]   output_budget;
  logic                              stream_tag;

  // line state
  lsplit_pkg::state_t state, state_next;
  logic [LW-1:0]                   line_length;
  logic                            trunc_flag;
  logic [lsplit_pkg::BUDGET_W-1:0] bytes_received;

  // drain bookkeeping, captured when a line is closed
  logic [LW-1:0] rd_idx;
  logic [LW-1:0] emit_len;
  logic          emit_trunc;

  // output register
  logic                          out_valid;
  logic [lsplit_pkg::BYTE_W-1:0] out_byte;
  logic                          out_byte_valid;
  logic                          out_last;
  logic                          out_trunc;
  logic                          out_stream;

  // line store
  logic                          ram_we;
  logic [lsplit_pkg::BYTE_W-1:0] ram_rdata;

  logic in_fire;
  logic out_free;
  logic in_ready;
  logic load_byte;
  logic load_empty;
  logic [lsplit_pkg::MAX_LINE_W-1:0] eff_limit;
  logic within_budget;
  logic is_finish;
  logic is_nl;
  logic is_cr;
  logic has_room;
  logic close_line;
  logic send_last;

  assign cfg.ready   = 1'b1;
  assign bytes.ready = in_ready;
  assign in_fire     = bytes.valid & in_ready;
  assign out_free    = ~out_valid | lines.ready;

  // zero acts as one, anything above the store size saturates
  always_comb begin
    if (max_line == '0) begin
      eff_limit = lsplit_pkg::MAX_LINE_W'(1);
    end else if (max_line > MAX_LIMIT) begin
      eff_limit = MAX_LIMIT;
    end else begin
      eff_limit = max_line;
    end
  end

  // decode of the incoming item
  assign is_finish     = (lsplit_pkg::cmd_t'(bytes.cmd) == lsplit_pkg::CMD_FINISH);
  assign within_budget = (bytes_received < output_budget);
  assign is_nl         = (bytes.data_byte == lsplit_pkg::CHAR_NL);
  assign is_cr         = (bytes.data_byte == lsplit_pkg::CHAR_CR);
  assign has_room      = (lsplit_pkg::MAX_LINE_W'(line_length) < eff_limit);

  // a finish closes a line only if something is pending; a newline within budget always does
  assign close_line = in_fire & (is_finish ? ((line_length != '0) | trunc_flag)
                                           : (within_budget & is_nl));

  // the store is written only between lines and read only while draining,
  // so no read can meet a write to the same entry
  assign ram_we = in_fire & ~is_finish & within_budget & ~is_nl & ~is_cr & has_room;

  assign send_last = (LW'(rd_idx + 1'b1) == emit_len);

  lsplit_ram #(
    .WIDTH (lsplit_pkg::BYTE_W),
    .DEPTH (MAX_LINE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (line_length[AW-1:0]),
    .wdata (bytes.data_byte),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lsplit_pkg::ST_IDLE: begin
        if (close_line) begin
          state_next = (line_length == '0) ? lsplit_pkg::ST_EMPTY : lsplit_pkg::ST_READ;
        end
      end
      lsplit_pkg::ST_READ: begin
        state_next = lsplit_pkg::ST_SEND;
      end
      lsplit_pkg::ST_SEND: begin
        if (out_free) begin
          state_next = send_last ? lsplit_pkg::ST_IDLE : lsplit_pkg::ST_READ;
        end
      end
      lsplit_pkg::ST_EMPTY: begin
        if (out_free) begin
          state_next = lsplit_pkg::ST_IDLE;
        end
      end
      default: state_next = lsplit_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    load_byte  = 1'b0;
    load_empty = 1'b0;
    unique case (state)
      lsplit_pkg::ST_IDLE:  in_ready   = 1'b1;
      lsplit_pkg::ST_READ:  ;
      lsplit_pkg::ST_SEND:  load_byte  = out_free;
      lsplit_pkg::ST_EMPTY: load_empty = out_free;
      default: ;
    endcase
  end

  // configuration writes; an index past the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      max_line      <= lsplit_pkg::MAX_LINE_RESET;
      output_budget <= lsplit_pkg::BUDGET_RESET;
      stream_tag    <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        lsplit_pkg::REG_MAX_LINE:
          max_line <= cfg.data[lsplit_pkg::MAX_LINE_W-1:0];
        lsplit_pkg::REG_BUDGET:
          output_budget <= cfg.data[lsplit_pkg::BUDGET_W-1:0];
        lsplit_pkg::REG_STREAM_TAG:
          stream_tag <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // line state and drain control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= lsplit_pkg::ST_IDLE;
      line_length    <= '0;
      trunc_flag     <= 1'b0;
      bytes_received <= '0;
      rd_idx         <= '0;
      emit_len       <= '0;
      emit_trunc     <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire && !is_finish) begin
        if (!within_budget) begin
          // budget spent: drop the byte, newlines too
          trunc_flag <= 1'b1;
        end else begin
          bytes_received <= bytes_received + 1'b1;
          if (!is_nl && !is_cr) begin
            if (has_room) begin
              line_length <= line_length + 1'b1;
            end else begin
              trunc_flag <= 1'b1;
            end
          end
        end
      end
      // snapshot the line and clear it; overrides the updates above
      if (close_line) begin
        emit_len    <= line_length;
        emit_trunc  <= trunc_flag;
        rd_idx      <= '0;
        line_length <= '0;
        trunc_flag  <= 1'b0;
      end
      if (load_byte) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  // output register: valid is control, payload loads without reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_byte || load_empty) begin
      out_valid <= 1'b1;
    end else if (lines.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_byte) begin
      out_byte       <= ram_rdata;
      out_byte_valid <= 1'b1;
      out_last       <= send_last;
      out_trunc      <= emit_trunc;
      out_stream     <= stream_tag;
    end else if (load_empty) begin
      out_byte       <= '0;
      out_byte_valid <= 1'b0;
      out_last       <= 1'b1;
      out_trunc      <= emit_trunc;
      out_stream     <= stream_tag;
    end
  end

  assign lines.valid      = out_valid;
  assign lines.line_byte  = out_byte;
  assign lines.byte_valid = out_byte_valid;
  assign lines.last       = out_last;
  assign lines.truncated  = out_trunc;
  assign lines.stream     = out_stream;

endmodule

>>> hdl/lsplit_checker.sv
// port-level checks for line_splitter_with_budget, bound to the top level
// depends on lsplit_pkg for field widths
module lsplit_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lsplit_pkg::BYTE_W-1:0] line_byte,
  input logic                          byte_valid,
  input logic                          last,
  input logic                          truncated
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(line_byte) && $stable(last)
      && $stable(truncated))
    else $error("result item changed while stalled");

  // no input taken while a line is still draining
  a_no_in_mid_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input ready in the middle of a line");

  // an empty line is a single item
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last)
    else $error("empty-line item without last");

  // an empty line carries a zero byte
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> line_byte == '0)
    else $error("empty-line item with nonzero byte");

endmodule

bind line_splitter_with_budget lsplit_checker u_lsplit_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (bytes.ready),
  .out_valid  (lines.valid),
  .out_ready  (lines.ready),
  .line_byte  (lines.line_byte),
  .byte_valid (lines.byte_valid),
  .last       (lines.last),
  .truncated  (lines.truncated)
);
